// ----- hdl/assert_macros.svh -----
// Assertion macros for the file that checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// An implication checked at each rising edge of i_clk outside of reset.
`define DSTX_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// A condition that must never hold at a rising edge of i_clk outside of reset.
`define DSTX_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

`endif

// ----- hdl/dstx_pkg.sv -----
// Package with the types, constants and widths of the framed byte receiver.
package dstx_pkg;

    localparam int FRAME_BYTES = 32;
    localparam int COUNT_W     = $clog2(FRAME_BYTES + 1);
    localparam int ADDR_W      = $clog2(FRAME_BYTES);
    localparam int SNAP_BYTES  = 19;
    localparam int Q_DEPTH     = 2;
    localparam int QPTR_W      = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(Q_DEPTH + 1);

    localparam logic [7:0] B_DLE  = 8'h10;
    localparam logic [7:0] B_STX  = 8'h02;
    localparam logic [7:0] B_ETX  = 8'h03;
    localparam logic [7:0] B_FILL = 8'hff;
    localparam logic [7:0] B_ZERO = 8'h00;

    localparam logic [1:0] KIND_ERROR = 2'd0;
    localparam logic [1:0] KIND_BOARD = 2'd1;
    localparam logic [1:0] KIND_CAN   = 2'd2;

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_STX,
        PH_BODY,
        PH_ESC
    } t_phase;

    typedef enum logic [2:0] {
        ERR_DLE,
        ERR_STX,
        ERR_ETX,
        ERR_CSUM,
        ERR_OVERFLOW,
        ERR_SHORT
    } t_err;

    typedef struct packed {
        logic                           is_frame;
        t_err                           err_code;
        logic [COUNT_W-1:0]             len;
        logic [SNAP_BYTES-1:0][7:0]     bytes;
    } t_entry;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [2:0]  error_code;
        logic [7:0]  board_id;
        logic [6:0]  board_command;
        logic        can_rtr;
        logic        can_extended;
        logic [28:0] can_ident;
        logic [31:0] can_timestamp;
        logic [7:0]  receive_flags;
        logic [7:0]  payload_length;
        logic [63:0] payload_bytes;
    } t_result;

endpackage

// ----- hdl/dstx_if.sv -----
// Valid/ready channel interfaces for received bytes and decoded results.
interface dstx_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface dstx_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [2:0]  error_code;
    logic [7:0]  board_id;
    logic [6:0]  board_command;
    logic        can_rtr;
    logic        can_extended;
    logic [28:0] can_ident;
    logic [31:0] can_timestamp;
    logic [7:0]  receive_flags;
    logic [7:0]  payload_length;
    logic [63:0] payload_bytes;

    modport source (
        output valid, output result_kind, output error_code, output board_id,
        output board_command, output can_rtr, output can_extended, output can_ident,
        output can_timestamp, output receive_flags, output payload_length,
        output payload_bytes, input ready
    );
    modport sink (
        input valid, input result_kind, input error_code, input board_id,
        input board_command, input can_rtr, input can_extended, input can_ident,
        input can_timestamp, input receive_flags, input payload_length,
        input payload_bytes, output ready
    );
endinterface

// ----- hdl/dstx_front.sv -----
// Front end: byte parser state machine, frame store, checksum and classification.
module dstx_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    dstx_rx_if.sink         i_rx,
    input  logic            i_q_full,
    output logic            o_push,
    output dstx_pkg::t_entry o_entry
);
    import dstx_pkg::*;

    t_phase             r_phase;
    t_phase             n_phase;
    t_phase             next_ph;
    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] n_count;
    logic [7:0]         r_xor;
    logic [7:0]         n_xor;
    logic [7:0]         r_store [FRAME_BYTES];
    logic               accept;
    logic               store_full;
    logic               wr_en;
    logic               clr;
    logic               push;
    logic               is_frame;
    t_err               err_code;
    logic [7:0]         b;

    assign i_rx.ready = !i_q_full;
    assign accept     = i_rx.valid && !i_q_full;
    assign b          = i_rx.rx_byte;
    assign store_full = (r_count == COUNT_W'(FRAME_BYTES));

    always_comb begin
        next_ph = r_phase;
        unique case (r_phase)
            PH_HUNT: next_ph = (b == B_DLE) ? PH_STX : PH_HUNT;
            PH_STX:  next_ph = (b == B_STX) ? PH_BODY : PH_HUNT;
            PH_BODY: begin
                if (b == B_DLE) begin
                    next_ph = PH_ESC;
                end else begin
                    next_ph = store_full ? PH_HUNT : PH_BODY;
                end
            end
            PH_ESC: begin
                if (b == B_ETX || b == B_STX || store_full) begin
                    next_ph = PH_HUNT;
                end else begin
                    next_ph = PH_BODY;
                end
            end
            default: next_ph = PH_HUNT;
        endcase
        n_phase = accept ? next_ph : r_phase;
    end

    always_comb begin
        push     = 1'b0;
        is_frame = 1'b0;
        err_code = ERR_DLE;
        wr_en    = 1'b0;
        clr      = 1'b0;
        unique case (r_phase)
            PH_HUNT: begin
                if (b == B_DLE) begin
                    clr = 1'b1;
                end else if (b != B_FILL) begin
                    push     = 1'b1;
                    err_code = ERR_DLE;
                end
            end
            PH_STX: begin
                if (b != B_STX) begin
                    push     = 1'b1;
                    err_code = ERR_STX;
                end
            end
            PH_BODY: begin
                if (b != B_DLE) begin
                    if (store_full) begin
                        push     = 1'b1;
                        err_code = ERR_OVERFLOW;
                    end else begin
                        wr_en = 1'b1;
                    end
                end
            end
            PH_ESC: begin
                if (b == B_ETX) begin
                    push = 1'b1;
                    if (r_xor != 8'h00) begin
                        err_code = ERR_CSUM;
                    end else if (r_count <= COUNT_W'(1)) begin
                        err_code = ERR_SHORT;
                    end else begin
                        is_frame = 1'b1;
                    end
                end else if (b == B_STX) begin
                    push     = 1'b1;
                    err_code = ERR_ETX;
                end else if (store_full) begin
                    push     = 1'b1;
                    err_code = ERR_OVERFLOW;
                end else begin
                    wr_en = 1'b1;
                end
            end
            default: push = 1'b0;
        endcase
    end

    always_comb begin
        n_count = r_count;
        n_xor   = r_xor;
        if (accept && clr) begin
            n_count = '0;
            n_xor   = '0;
        end else if (accept && wr_en) begin
            n_count = r_count + COUNT_W'(1);
            n_xor   = r_xor ^ b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_count <= '0;
            r_xor   <= '0;
        end else begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_xor   <= n_xor;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && wr_en) begin
            r_store[r_count[ADDR_W-1:0]] <= b;
        end
    end

    assign o_push           = accept && push;
    assign o_entry.is_frame = is_frame;
    assign o_entry.err_code = err_code;
    assign o_entry.len      = r_count - COUNT_W'(1);

    for (genvar k = 0; k < SNAP_BYTES; k++) begin : g_snap
        assign o_entry.bytes[k] = r_store[k];
    end

endmodule

// ----- hdl/dstx_queue.sv -----
// Short queue of classified items between the front and back ends.
module dstx_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  dstx_pkg::t_entry i_entry,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_valid,
    output dstx_pkg::t_entry o_entry
);
    import dstx_pkg::*;

    t_entry            r_mem [Q_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_cnt;
    logic [QPTR_W-1:0] n_wr;
    logic [QPTR_W-1:0] n_rd;
    logic [QCNT_W-1:0] n_cnt;
    logic              do_pop;

    assign o_full  = (r_cnt == QCNT_W'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_entry = r_mem[r_rd];
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == QPTR_W'(Q_DEPTH - 1)) ? '0 : r_wr + QPTR_W'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == QPTR_W'(Q_DEPTH - 1)) ? '0 : r_rd + QPTR_W'(1);
        end
        if (i_push && !do_pop) begin
            n_cnt = r_cnt + QCNT_W'(1);
        end else if (!i_push && do_pop) begin
            n_cnt = r_cnt - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

endmodule

// ----- hdl/dstx_back.sv -----
// Back end: decodes a queued item into a result and holds it in the output register.
module dstx_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  dstx_pkg::t_entry i_entry,
    output logic             o_pop,
    dstx_res_if.source       o_res
);
    import dstx_pkg::*;

    logic       r_valid;
    t_result    r_res;
    t_result    dec;
    logic [7:0] pk [SNAP_BYTES];
    logic [7:0] plen;
    logic       load;

    always_comb begin
        for (int k = 0; k < SNAP_BYTES; k++) begin
            pk[k] = (COUNT_W'(k) < i_entry.len) ? i_entry.bytes[k] : 8'h00;
        end
        dec  = '0;
        plen = '0;
        if (!i_entry.is_frame) begin
            dec.result_kind = KIND_ERROR;
            dec.error_code  = i_entry.err_code;
        end else if (pk[0] == B_ZERO || pk[0] == B_FILL) begin
            plen = (i_entry.len >= COUNT_W'(2)) ? 8'(i_entry.len) - 8'd2 : 8'd0;
            dec.result_kind    = KIND_BOARD;
            dec.board_id       = pk[0];
            dec.board_command  = pk[1][6:0];
            dec.payload_length = plen;
            for (int i = 0; i < 8; i++) begin
                if (8'(i) < plen) begin
                    dec.payload_bytes[8*i +: 8] = pk[2 + i];
                end
            end
        end else begin
            dec.result_kind    = KIND_CAN;
            dec.can_rtr        = pk[0][6];
            dec.can_extended   = pk[0][5];
            dec.can_ident      = {pk[4][4:0], pk[3], pk[2], pk[1]};
            dec.can_timestamp  = {pk[8], pk[7], pk[6], pk[5]};
            dec.receive_flags  = pk[9];
            dec.payload_length = pk[10];
            for (int i = 0; i < 8; i++) begin
                if (8'(i) < pk[10]) begin
                    dec.payload_bytes[8*i +: 8] = pk[11 + i];
                end
            end
        end
    end

    assign load  = i_q_valid && (!r_valid || o_res.ready);
    assign o_pop = load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res <= dec;
        end
    end

    assign o_res.valid          = r_valid;
    assign o_res.result_kind    = r_res.result_kind;
    assign o_res.error_code     = r_res.error_code;
    assign o_res.board_id       = r_res.board_id;
    assign o_res.board_command  = r_res.board_command;
    assign o_res.can_rtr        = r_res.can_rtr;
    assign o_res.can_extended   = r_res.can_extended;
    assign o_res.can_ident      = r_res.can_ident;
    assign o_res.can_timestamp  = r_res.can_timestamp;
    assign o_res.receive_flags  = r_res.receive_flags;
    assign o_res.payload_length = r_res.payload_length;
    assign o_res.payload_bytes  = r_res.payload_bytes;

endmodule

// ----- hdl/dle_stx_frame_receiver_core.sv -----
// Top level of the DLE STX / DLE ETX framed byte receiver.
// The receiver takes one raw link byte per item on i_rx and hunts for DLE STX.
// Inside a frame DLE DLE is a data byte 0x10, DLE ETX closes the frame and
// DLE STX is reported as an error. A closed frame of two or more bytes with zero
// XOR is decoded as a board message (first byte 0x00 or 0xff) or as a CAN bus message.
// Each byte yields at most one item on o_res: an error report or a message.
// One byte is taken per cycle while i_rx.ready is high; the parser state machine
// updates phase, store and checksum for each byte that it takes.
// A result passes from the byte that causes it through the two-entry queue and
// then the output register before it appears on o_res.
// When o_res stalls, bytes are still taken until the queue is full, then
// i_rx.ready drops until the output register is drained.
// Reset clears the phase to hunting, the count and the checksum, and empties
// the queue and the output register; the frame store needs no clearing.
// Frames longer than the store report an overflow and the parser hunts again.
module dle_stx_frame_receiver_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dstx_rx_if.sink    i_rx,
    dstx_res_if.source o_res
);
    import dstx_pkg::*;

    `include "assert_macros.svh"

    logic   push;
    logic   q_full;
    logic   q_valid;
    logic   pop;
    t_entry push_entry;
    t_entry head_entry;

    dstx_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rx     (i_rx),
        .i_q_full (q_full),
        .o_push   (push),
        .o_entry  (push_entry)
    );

    dstx_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_entry (head_entry)
    );

    dstx_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_entry   (head_entry),
        .o_pop     (pop),
        .o_res     (o_res)
    );

    `DSTX_ASSERT_NEVER(a_no_push_full, push && q_full, "item pushed into a full queue")
    `DSTX_ASSERT_IMP(a_err_clean, o_res.valid && o_res.result_kind == KIND_ERROR, o_res.board_id == 8'h00 && o_res.payload_bytes == 64'h0 && o_res.payload_length == 8'h00, "error report carries message fields")
    `DSTX_ASSERT_IMP(a_board_len, o_res.valid && o_res.result_kind == KIND_BOARD, o_res.payload_length <= 8'(FRAME_BYTES - 3), "board payload length exceeds the frame store")
    `DSTX_ASSERT_IMP(a_pop_valid, pop, q_valid, "back end popped an empty queue")

endmodule
